// ===== hdl/bfe_pkg.sv =====
package bfe_pkg;

    // Field widths
    localparam int COORD_W   = 15;
    localparam int FIT_W     = 48;
    localparam int MODE_W    = 3;
    localparam int CNT_W     = 6;
    localparam int NUM_GROUPS = 5;
    localparam int REG_IDX_W = 3;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    // Fixed-point constants (Q3.12 coordinates)
    localparam int ONE_Q12  = 4096;
    localparam int NEAR_LSB = 2;

    // Benchmark modes
    localparam logic [MODE_W-1:0] MODE_THROUGH = 3'd0;
    localparam logic [MODE_W-1:0] MODE_STAR    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PAIR    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PAIR_SQ = 3'd3;
    localparam logic [MODE_W-1:0] MODE_GROUP   = 3'd4;

    // Register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_MODE         = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROSEN_COUNT  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SPHERE_COUNT = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GROUP_A      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_GROUP_B      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_GROUP_C      = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_GROUP_D      = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_GROUP_E      = 3'd7;

    // Reset values of the registers
    localparam logic [MODE_W-1:0] MODE_RESET   = MODE_GROUP;
    localparam logic [CNT_W-1:0]  ROSEN_RESET  = 6'd4;
    localparam logic [CNT_W-1:0]  SPHERE_RESET = 6'd20;
    localparam logic [CNT_W-1:0]  GROUP_A_RESET = 6'd8;
    localparam logic [CNT_W-1:0]  GROUP_X_RESET = 6'd2;

    typedef struct packed {
        logic [MODE_W-1:0]                 mode;
        logic [CNT_W-1:0]                  rosen_count;
        logic [CNT_W-1:0]                  sphere_count;
        logic [NUM_GROUPS-1:0][CNT_W-1:0]  group_size;
    } cfg_t;

    // Controller to datapath: one step per flag
    typedef struct packed {
        logic accept;
        logic sq;
        logic esq;
        logic mid;
        logic big;
        logic acc;
        logic flush;
        logic out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last;
        logic grp_done;
    } stat_t;

endpackage

// ===== hdl/bfe_regs.sv =====
module bfe_regs
    import bfe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready,
    output cfg_t                 cfg
);

    cfg_t                   cfg_reg;
    logic [REG_IDX_W-1:0]   reg_idx;
    logic                   wr_en;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode          <= MODE_RESET;
            cfg_reg.rosen_count   <= ROSEN_RESET;
            cfg_reg.sphere_count  <= SPHERE_RESET;
            cfg_reg.group_size[0] <= GROUP_A_RESET;
            cfg_reg.group_size[1] <= GROUP_X_RESET;
            cfg_reg.group_size[2] <= GROUP_X_RESET;
            cfg_reg.group_size[3] <= GROUP_X_RESET;
            cfg_reg.group_size[4] <= GROUP_X_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_MODE:         cfg_reg.mode          <= pwdata[MODE_W-1:0];
                REG_ROSEN_COUNT:  cfg_reg.rosen_count   <= pwdata[CNT_W-1:0];
                REG_SPHERE_COUNT: cfg_reg.sphere_count  <= pwdata[CNT_W-1:0];
                REG_GROUP_A:      cfg_reg.group_size[0] <= pwdata[CNT_W-1:0];
                REG_GROUP_B:      cfg_reg.group_size[1] <= pwdata[CNT_W-1:0];
                REG_GROUP_C:      cfg_reg.group_size[2] <= pwdata[CNT_W-1:0];
                REG_GROUP_D:      cfg_reg.group_size[3] <= pwdata[CNT_W-1:0];
                REG_GROUP_E:      cfg_reg.group_size[4] <= pwdata[CNT_W-1:0];
                default:          cfg_reg.mode          <= cfg_reg.mode;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_MODE:         prdata = PDATA_W'(cfg_reg.mode);
            REG_ROSEN_COUNT:  prdata = PDATA_W'(cfg_reg.rosen_count);
            REG_SPHERE_COUNT: prdata = PDATA_W'(cfg_reg.sphere_count);
            REG_GROUP_A:      prdata = PDATA_W'(cfg_reg.group_size[0]);
            REG_GROUP_B:      prdata = PDATA_W'(cfg_reg.group_size[1]);
            REG_GROUP_C:      prdata = PDATA_W'(cfg_reg.group_size[2]);
            REG_GROUP_D:      prdata = PDATA_W'(cfg_reg.group_size[3]);
            REG_GROUP_E:      prdata = PDATA_W'(cfg_reg.group_size[4]);
            default:          prdata = '0;
        endcase
    end

endmodule

// ===== hdl/bfe_ctrl.sv =====
module bfe_ctrl
    import bfe_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    output logic   out_valid,
    input  logic   out_ready,
    input  stat_t  stat,
    output cmd_t   cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_ESQ,
        ST_MID,
        ST_BIG,
        ST_ACC,
        ST_FLUSH,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_busy;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    // A result still waiting that is not taken in this cycle
    assign out_busy  = out_valid_reg && !out_ready;

    // Command decode
    always_comb
    begin
        cmd          = '0;
        cmd.accept   = in_valid && (state_reg == ST_IDLE);
        cmd.sq       = (state_reg == ST_SQ);
        cmd.esq      = (state_reg == ST_ESQ);
        cmd.mid      = (state_reg == ST_MID);
        cmd.big      = (state_reg == ST_BIG);
        cmd.acc      = (state_reg == ST_ACC);
        cmd.flush    = (state_reg == ST_FLUSH);
        cmd.out_load = (state_reg == ST_DONE) && !out_busy;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_SQ;
            end
            ST_SQ:  state_next = ST_ESQ;
            ST_ESQ: state_next = ST_MID;
            ST_MID: state_next = ST_BIG;
            ST_BIG: state_next = ST_ACC;
            ST_ACC:
            begin
                if (stat.grp_done)
                    state_next = ST_FLUSH;
                else if (stat.last)
                    state_next = ST_DONE;
                else
                    state_next = ST_IDLE;
            end
            ST_FLUSH:
            begin
                state_next = stat.last ? ST_DONE : ST_IDLE;
            end
            ST_DONE:
            begin
                if (!out_busy)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Result valid: set on load, cleared on transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTH
    a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result valid rose outside the done state");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> state_reg == ST_SQ)
        else $error("accepted coordinate did not start the multiply sequence");

    a_load_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !cmd.out_load)
        else $error("pending result overwritten");
`endif

endmodule

// ===== hdl/bfe_dp.sv =====
module bfe_dp
    import bfe_pkg::*;
#(
    parameter int DIMENSIONS = 36
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  cmd_t                       cmd,
    input  logic signed [COORD_W-1:0]  coord_value,
    output stat_t                      stat,
    output logic [FIT_W-1:0]           fitness,
    output logic                       near_optimum
);

    localparam int IDX_W = $clog2(DIMENSIONS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIMENSIONS - 1);

    // What the accepted coordinate does to the sums
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_HEAD,
        ACT_ROSEN,
        ACT_GROUP_HEAD,
        ACT_GROUP_TERM,
        ACT_SPHERE,
        ACT_PAIR_FIRST,
        ACT_PAIR_SECOND
    } act_t;

    function automatic logic [FIT_W-1:0] sat_add(input logic [FIT_W-1:0] a,
                                                 input logic [FIT_W-1:0] b);
        logic [FIT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[FIT_W] ? {FIT_W{1'b1}} : s[FIT_W-1:0];
    endfunction

    // Candidate state
    logic [FIT_W-1:0]          fitness_reg;
    logic [FIT_W-1:0]          pending_reg;
    logic signed [COORD_W-1:0] head_reg;
    logic [28:0]               pair_reg;
    logic [IDX_W-1:0]          coord_idx_reg;
    logic [2:0]                grp_idx_reg;
    logic [CNT_W-1:0]          pos_reg;
    logic                      all_near_reg;

    // Per-coordinate work registers
    logic signed [COORD_W-1:0] x_reg;
    act_t                      act_reg;
    logic                      last_reg;
    logic                      grp_done_reg;
    logic signed [15:0]        e_reg;
    logic [28:0]               sq_reg;
    logic [28:0]               esq_reg;
    logic [28:0]               ad_reg;
    logic [57:0]               dsq_reg;
    logic [29:0]               s_reg;
    logic [35:0]               ssq_reg;
    logic [41:0]               rterm_reg;

    // Result registers
    logic [FIT_W-1:0]          fit_out_reg;
    logic                      near_out_reg;

    // Combinational helpers
    act_t                      act_next;
    logic                      grp_done_next;
    logic [CNT_W-1:0]          size_cur;
    logic [7:0]                idx8;
    logic [7:0]                t1;
    logic [7:0]                t2;
    logic [7:0]                t4;
    logic [7:0]                t1_l;
    logic [7:0]                t2_l;
    logic signed [15:0]        e_next;
    logic signed [30:0]        d_val;
    logic signed [30:0]        d_neg;
    logic [28:0]               ad_next;
    logic signed [30:0]        mul_op;
    logic signed [61:0]        prod;
    logic [64:0]               dsq_ext;
    logic [64:0]               dsq_x100;
    logic [41:0]               rterm_next;
    logic [FIT_W-1:0]          term;
    logic                      near_now;

    assign stat.last     = last_reg;
    assign stat.grp_done = grp_done_reg;
    assign fitness       = fit_out_reg;
    assign near_optimum  = near_out_reg;

    // Size of the current star group; a size of zero acts as one
    always_comb
    begin
        case (grp_idx_reg)
            3'd0:    size_cur = cfg.group_size[0];
            3'd1:    size_cur = cfg.group_size[1];
            3'd2:    size_cur = cfg.group_size[2];
            3'd3:    size_cur = cfg.group_size[3];
            3'd4:    size_cur = cfg.group_size[4];
            default: size_cur = '0;
        endcase
    end

    // Classify the incoming coordinate by mode and position
    always_comb
    begin
        idx8 = 8'(coord_idx_reg);
        t1   = 8'(cfg.rosen_count);
        t2   = {1'b0, cfg.rosen_count, 1'b0};
        t4   = {cfg.rosen_count, 2'b00};
        t1_l = t1 + 8'(cfg.sphere_count);
        t2_l = t2 + 8'(cfg.sphere_count);
        grp_done_next = 1'b0;
        act_next = ACT_NONE;
        unique case (cfg.mode) inside
            MODE_STAR:
            begin
                if (idx8 < t1)
                    act_next = (idx8 == 8'd0) ? ACT_HEAD : ACT_ROSEN;
                else if (idx8 < t1_l)
                    act_next = ACT_SPHERE;
            end
            MODE_PAIR, MODE_PAIR_SQ:
            begin
                if (idx8 < t2)
                    act_next = idx8[0] ? ACT_ROSEN : ACT_HEAD;
                else if (cfg.mode == MODE_PAIR)
                begin
                    if (idx8 < t2_l)
                        act_next = ACT_SPHERE;
                end
                else if (idx8 < t4)
                    act_next = idx8[0] ? ACT_PAIR_SECOND : ACT_PAIR_FIRST;
            end
            MODE_GROUP:
            begin
                if (grp_idx_reg < 3'(NUM_GROUPS))
                begin
                    act_next = (pos_reg == '0) ? ACT_GROUP_HEAD : ACT_GROUP_TERM;
                    grp_done_next = ({1'b0, pos_reg} + 7'd1) >= {1'b0, size_cur};
                end
                else
                    act_next = ACT_SPHERE;
            end
            default: act_next = ACT_NONE;
        endcase
    end

    // Offset from 1.0 and the Rosenbrock difference
    always_comb
    begin
        e_next  = 16'(x_reg) - 16'(ONE_Q12);
        d_val   = (31'(head_reg) <<< 12) - $signed({2'b00, sq_reg});
        d_neg   = -d_val;
        ad_next = d_val[30] ? d_neg[28:0] : d_val[28:0];
    end

    // Shared squarer: x, x-1, head difference, pair sum in turn
    always_comb
    begin
        if (cmd.sq)
            mul_op = 31'(x_reg);
        else if (cmd.esq)
            mul_op = 31'(e_reg);
        else if (cmd.mid)
            mul_op = $signed({2'b00, ad_reg});
        else
            mul_op = $signed({1'b0, s_reg});
        prod = mul_op * mul_op;
    end

    // 100 * diff^2, floored from 2^48 to Q.24, plus (x-1)^2
    always_comb
    begin
        dsq_ext    = {7'd0, dsq_reg};
        dsq_x100   = (dsq_ext << 6) + (dsq_ext << 5) + (dsq_ext << 2);
        rterm_next = {1'b0, dsq_x100[64:24]} + 42'(esq_reg);
    end

    // Term added at the accumulate step
    always_comb
    begin
        case (act_reg) inside
            ACT_ROSEN, ACT_GROUP_TERM: term = FIT_W'(rterm_reg);
            ACT_SPHERE:                term = FIT_W'(esq_reg);
            ACT_PAIR_SECOND:           term = FIT_W'(ssq_reg);
            default:                   term = '0;
        endcase
        near_now = (e_reg >= -16'(NEAR_LSB)) && (e_reg <= 16'(NEAR_LSB));
    end

    // Candidate state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fitness_reg   <= '0;
            pending_reg   <= '0;
            head_reg      <= '0;
            pair_reg      <= '0;
            coord_idx_reg <= '0;
            grp_idx_reg   <= '0;
            pos_reg       <= '0;
            all_near_reg  <= 1'b1;
            act_reg       <= ACT_NONE;
            last_reg      <= 1'b0;
            grp_done_reg  <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            fitness_reg   <= '0;
            pending_reg   <= '0;
            head_reg      <= '0;
            pair_reg      <= '0;
            coord_idx_reg <= '0;
            grp_idx_reg   <= '0;
            pos_reg       <= '0;
            all_near_reg  <= 1'b1;
        end
        else if (cmd.accept)
        begin
            act_reg      <= act_next;
            last_reg     <= (coord_idx_reg >= LAST_IDX);
            grp_done_reg <= grp_done_next;
        end
        else if (cmd.acc)
        begin
            if (!near_now)
                all_near_reg <= 1'b0;
            if (!last_reg)
                coord_idx_reg <= coord_idx_reg + IDX_W'(1);
            case (act_reg) inside
                ACT_HEAD, ACT_GROUP_HEAD:
                    head_reg <= x_reg;
                ACT_ROSEN, ACT_SPHERE, ACT_PAIR_SECOND:
                    fitness_reg <= sat_add(fitness_reg, term);
                ACT_GROUP_TERM:
                    pending_reg <= sat_add(pending_reg, term);
                ACT_PAIR_FIRST:
                    pair_reg <= esq_reg;
                default:
                    pair_reg <= pair_reg;
            endcase
            // Star group bookkeeping
            if (act_reg == ACT_GROUP_HEAD || act_reg == ACT_GROUP_TERM)
            begin
                if (grp_done_reg)
                begin
                    grp_idx_reg <= grp_idx_reg + 3'd1;
                    pos_reg     <= '0;
                end
                else
                    pos_reg <= pos_reg + CNT_W'(1);
            end
        end
        else if (cmd.flush)
        begin
            fitness_reg <= sat_add(fitness_reg, pending_reg);
            pending_reg <= '0;
        end
    end

    // Work registers and result
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            x_reg <= coord_value;
        if (cmd.sq)
        begin
            sq_reg <= prod[28:0];
            e_reg  <= e_next;
        end
        if (cmd.esq)
        begin
            esq_reg <= prod[28:0];
            ad_reg  <= ad_next;
        end
        if (cmd.mid)
        begin
            dsq_reg <= prod[57:0];
            s_reg   <= {1'b0, pair_reg} + {1'b0, esq_reg};
        end
        if (cmd.big)
        begin
            ssq_reg   <= prod[59:24];
            rterm_reg <= rterm_next;
        end
        if (cmd.out_load)
        begin
            fit_out_reg  <= fitness_reg;
            near_out_reg <= all_near_reg;
        end
    end

`ifndef SYNTH
    a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (fitness_reg == '0) && all_near_reg && (coord_idx_reg == '0))
        else $error("candidate state not cleared after result");

    a_flush_only_on_group_end: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |-> grp_done_reg && (act_reg == ACT_GROUP_HEAD
                                       || act_reg == ACT_GROUP_TERM))
        else $error("group flush without a completed group");

    a_term_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc && act_reg == ACT_GROUP_TERM |-> pos_reg != '0)
        else $error("group term taken at group head position");
`endif

endmodule

// ===== hdl/benchmark_fitness_evaluator.sv =====
// Composite Rosenbrock/sphere benchmark evaluator. Send the coordinates of one
// candidate as signed Q3.12 values, index 0 first; after coordinate DIMENSIONS-1
// the block returns one transfer with the fitness (unsigned Q24.24, saturating at
// 2^48-1) and near_optimum (every coordinate within 2 LSB of 1.0), then starts
// the next candidate. Each coordinate passes through accept, four squaring
// steps and one accumulate step, plus a flush step when it closes a mode-4
// star group; after the last one a done step loads the result, waiting there
// while the previous result has not been taken. No new coordinate is taken
// until these steps end, as the single shared squarer forms x*x, (x-1)^2,
// the Rosenbrock difference square and the mode-3 pair-sum square in turn.
// Registers (APB, byte address 4*index): mode, rosen_count, sphere_count,
// group_size_a..e; write them only while no candidate is in progress.
module benchmark_fitness_evaluator
    import bfe_pkg::*;
#(
    parameter int DIMENSIONS = 36
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [PDATA_W-1:0]         pwdata,
    output logic [PDATA_W-1:0]         prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [COORD_W-1:0]  coord_value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [FIT_W-1:0]           fitness,
    output logic                       near_optimum
);

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;

    bfe_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bfe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bfe_dp #(
        .DIMENSIONS (DIMENSIONS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .coord_value  (coord_value),
        .stat         (stat),
        .fitness      (fitness),
        .near_optimum (near_optimum)
    );

endmodule

// ===== test/tb_top.sv =====
module tb_top;
    import bfe_pkg::*;

    localparam int DIMS          = 36;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_WAIT      = 14;
    localparam int RANDOM_ITEMS  = 520;
    localparam int COORD_LO      = -8389;
    localparam int COORD_HI      = 8384;
    localparam logic [63:0] FIT_MAX = 64'hFFFF_FFFF_FFFF;

    // Mode codes the block treats as pass-through
    localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    typedef enum {STYLE_RANGE, STYLE_NEAR, STYLE_NEAR_MISS, STYLE_WIDE, STYLE_CORNER}
        coord_style_t;

    typedef struct {
        logic [FIT_W-1:0] fitness;
        logic             near;
    } fitness_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [PADDR_W-1:0]        paddr;
    logic [PDATA_W-1:0]        pwdata;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [COORD_W-1:0] coord_value;
    logic                      out_valid;
    logic                      out_ready;
    logic [FIT_W-1:0]          fitness;
    logic                      near_optimum;

    // Shadow of the configuration registers
    logic [MODE_W-1:0] cfg_mode;
    logic [CNT_W-1:0]  cfg_rosen;
    logic [CNT_W-1:0]  cfg_sphere;
    logic [CNT_W-1:0]  cfg_group [NUM_GROUPS];

    // Per-candidate accumulation state
    logic [FIT_W-1:0]          acc_fitness;
    logic [FIT_W-1:0]          acc_group;
    logic signed [COORD_W-1:0] star_head;
    logic [31:0]               half_pair;
    int unsigned               idx_coord;
    int unsigned               idx_group;
    int unsigned               grp_pos;
    logic                      near_so_far;

    fitness_result_t expected_fitness [$];
    int              mismatch_count = 0;
    int              items_sent = 0;
    int              cycle_count = 0;
    bit              idle_off = 1'b0;

    always #5 clk = ~clk;

    benchmark_fitness_evaluator #(.DIMENSIONS(DIMS)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .coord_value  (coord_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .fitness      (fitness),
        .near_optimum (near_optimum)
    );

    // Run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Fitness arithmetic
    // ---------------------------------------------------------------

    // (x - 1.0)^2 in Q.24
    function automatic logic [63:0] dev_square(input logic signed [COORD_W-1:0] x);
        longint e;
        e = longint'(x) - ONE_Q12;
        return e * e;
    endfunction

    // floor(v * k / 2^24) without overflow
    function automatic logic [63:0] floor_q24(input logic [63:0] v, input logic [63:0] k);
        return (v >> 24) * k + (((v & 64'hFF_FFFF) * k) >> 24);
    endfunction

    // 100*(h - x*x)^2 + (x - 1)^2, exact then floored to Q.24
    function automatic logic [63:0] rosen_value(input logic signed [COORD_W-1:0] h,
                                                input logic signed [COORD_W-1:0] x);
        longint      d;
        logic [63:0] ad;
        d  = longint'(h) * 4096 - longint'(x) * longint'(x);
        ad = (d < 0) ? -d : d;
        return floor_q24(ad * ad, 100) + dev_square(x);
    endfunction

    function automatic logic [FIT_W-1:0] add_sat(input logic [FIT_W-1:0] a,
                                                 input logic [63:0] b);
        logic [63:0] s;
        s = {16'b0, a} + b;
        return (s > FIT_MAX) ? FIT_MAX[FIT_W-1:0] : s[FIT_W-1:0];
    endfunction

    function automatic void clear_candidate();
        acc_fitness = '0;
        acc_group   = '0;
        star_head   = '0;
        half_pair   = '0;
        idx_coord   = 0;
        idx_group   = 0;
        grp_pos     = 0;
        near_so_far = 1'b1;
    endfunction

    // Fold one accepted coordinate into the candidate; queue the result on the last one
    function automatic void predict_coord(input logic signed [COORD_W-1:0] x);
        int unsigned     t;
        int unsigned     l;
        int              dev;
        logic [63:0]     sq;
        logic [63:0]     pair_sum;
        fitness_result_t res;
        t   = cfg_rosen;
        l   = cfg_sphere;
        dev = int'(x) - ONE_Q12;
        if (dev < -NEAR_LSB || dev > NEAR_LSB)
            near_so_far = 1'b0;

        case (cfg_mode) inside
            MODE_STAR:
            begin
                if (idx_coord < t)
                begin
                    if (idx_coord == 0)
                        star_head = x;
                    else
                        acc_fitness = add_sat(acc_fitness, rosen_value(star_head, x));
                end
                else if (idx_coord < t + l)
                    acc_fitness = add_sat(acc_fitness, dev_square(x));
            end
            MODE_PAIR, MODE_PAIR_SQ:
            begin
                if (idx_coord < 2 * t)
                begin
                    if (idx_coord[0] == 1'b0)
                        star_head = x;
                    else
                        acc_fitness = add_sat(acc_fitness, rosen_value(star_head, x));
                end
                else if (cfg_mode == MODE_PAIR)
                begin
                    if (idx_coord < 2 * t + l)
                        acc_fitness = add_sat(acc_fitness, dev_square(x));
                end
                else if (idx_coord < 4 * t)
                begin
                    sq = dev_square(x);
                    if (idx_coord[0] == 1'b0)
                        half_pair = sq[31:0];
                    else
                    begin
                        pair_sum    = {32'b0, half_pair} + sq;
                        acc_fitness = add_sat(acc_fitness, floor_q24(pair_sum * pair_sum, 1));
                    end
                end
            end
            MODE_GROUP:
            begin
                if (idx_group < NUM_GROUPS)
                begin
                    if (grp_pos == 0)
                        star_head = x;
                    else
                        acc_group = add_sat(acc_group, rosen_value(star_head, x));
                    grp_pos++;
                    // group closes; size zero behaves as size one
                    if (grp_pos >= cfg_group[idx_group])
                    begin
                        acc_fitness = add_sat(acc_fitness, {16'b0, acc_group});
                        acc_group   = '0;
                        idx_group++;
                        grp_pos     = 0;
                    end
                end
                else
                    acc_fitness = add_sat(acc_fitness, dev_square(x));
            end
            default:
            begin
                // pass-through and unused modes add nothing
            end
        endcase

        if (idx_coord >= DIMS - 1)
        begin
            res.fitness = acc_fitness;
            res.near    = near_so_far;
            expected_fitness.insert(expected_fitness.size(), res);
            clear_candidate();
        end
        else
            idx_coord = (idx_coord + 1) & 63;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic logic signed [COORD_W-1:0] pick_coord(input coord_style_t style);
        int r;
        int corner [8];
        corner = '{-16384, 16383, COORD_LO, COORD_HI, 0, -1, 1, ONE_Q12};
        case (style)
            STYLE_NEAR, STYLE_NEAR_MISS:
                r = ONE_Q12 - NEAR_LSB + int'($urandom_range(0, 2 * NEAR_LSB));
            STYLE_WIDE:
                r = int'($urandom_range(0, 32767)) - 16384;
            STYLE_CORNER:
                r = corner[$urandom_range(0, 7)];
            default:
                r = int'($urandom_range(0, COORD_HI - COORD_LO)) + COORD_LO;
        endcase
        return r[COORD_W-1:0];
    endfunction

    // One coordinate transfer; valid stays up across back-to-back items
    task automatic send_coord(input logic signed [COORD_W-1:0] v);
        int gap;
        gap = idle_off ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        coord_value <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_coord(v);
        items_sent++;
    endtask

    task automatic send_candidate(input coord_style_t style);
        int miss_at;
        int off;
        miss_at = (style == STYLE_NEAR_MISS) ? $urandom_range(0, DIMS - 1) : -1;
        for (int k = 0; k < DIMS; k++)
        begin
            if (k == miss_at)
            begin
                // just outside the near-optimum window on either side
                off = $urandom_range(0, 1) ? NEAR_LSB + 1 : -(NEAR_LSB + 1);
                send_coord(COORD_W'(ONE_Q12 + off));
            end
            else
                send_coord(pick_coord(style));
        end
    endtask

    // Drain everything in flight before touching registers
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_fitness.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MODE:         cfg_mode   = val[MODE_W-1:0];
            REG_ROSEN_COUNT:  cfg_rosen  = val[CNT_W-1:0];
            REG_SPHERE_COUNT: cfg_sphere = val[CNT_W-1:0];
            REG_GROUP_A:      cfg_group[0] = val[CNT_W-1:0];
            REG_GROUP_B:      cfg_group[1] = val[CNT_W-1:0];
            REG_GROUP_C:      cfg_group[2] = val[CNT_W-1:0];
            REG_GROUP_D:      cfg_group[3] = val[CNT_W-1:0];
            REG_GROUP_E:      cfg_group[4] = val[CNT_W-1:0];
            default:
            begin
            end
        endcase
        @(posedge clk);
    endtask

    task automatic load_config(input logic [MODE_W-1:0] m, input int t, input int l,
                               input int ga, input int gb, input int gc,
                               input int gd, input int ge);
        wait_idle();
        write_reg(REG_MODE, PDATA_W'(m));
        write_reg(REG_ROSEN_COUNT, PDATA_W'(t));
        write_reg(REG_SPHERE_COUNT, PDATA_W'(l));
        write_reg(REG_GROUP_A, PDATA_W'(ga));
        write_reg(REG_GROUP_B, PDATA_W'(gb));
        write_reg(REG_GROUP_C, PDATA_W'(gc));
        write_reg(REG_GROUP_D, PDATA_W'(gd));
        write_reg(REG_GROUP_E, PDATA_W'(ge));
    endtask

    task automatic log_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] %s mismatch: expected %0d (0x%h), got %0d (0x%h)",
                     $realtime, what, want, want, got, got);
    endtask

    // ---------------------------------------------------------------
    // Result side: random back-pressure and checking
    // ---------------------------------------------------------------
    initial
    begin : result_checker
        int              stall;
        fitness_result_t want;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = idle_off ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            // transfer happened at this edge
            if (expected_fitness.size() == 0)
                log_mismatch("unexpected result, fitness", '0, {16'b0, fitness});
            else
            begin
                want = expected_fitness.pop_front();
                if (fitness !== want.fitness)
                    log_mismatch("fitness", {16'b0, want.fitness}, {16'b0, fitness});
                if (near_optimum !== want.near)
                    log_mismatch("near_optimum", {63'b0, want.near}, {63'b0, near_optimum});
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Reset register values: grouped mode with 8,2,2,2,2
    task automatic test_reset_config();
        send_candidate(STYLE_RANGE);
        send_candidate(STYLE_NEAR);
    endtask

    // Each mode code, the unused ones included
    task automatic test_every_mode();
        logic [MODE_W-1:0] modes [8];
        modes = '{MODE_THROUGH, MODE_STAR, MODE_PAIR, MODE_PAIR_SQ, MODE_GROUP,
                  MODE_SPARE_5, MODE_SPARE_6, MODE_SPARE_7};
        foreach (modes[k])
        begin
            load_config(modes[k], 9, 10, 3, 4, 5, 6, 7);
            send_candidate(STYLE_RANGE);
        end
    endtask

    // Count and group size extremes, incomplete groups and pairs
    task automatic test_count_extremes();
        load_config(MODE_STAR, 0, 0, GROUP_A_RESET, 2, 2, 2, 2);
        send_candidate(STYLE_RANGE);
        load_config(MODE_STAR, 36, 0, GROUP_A_RESET, 2, 2, 2, 2);
        send_candidate(STYLE_RANGE);
        load_config(MODE_STAR, 1, 36, GROUP_A_RESET, 2, 2, 2, 2);
        send_candidate(STYLE_RANGE);
        load_config(MODE_STAR, 63, 63, GROUP_A_RESET, 2, 2, 2, 2);
        send_candidate(STYLE_RANGE);
        load_config(MODE_PAIR, 0, 36, GROUP_A_RESET, 2, 2, 2, 2);
        send_candidate(STYLE_RANGE);
        load_config(MODE_PAIR, 18, 0, GROUP_A_RESET, 2, 2, 2, 2);
        send_candidate(STYLE_RANGE);
        load_config(MODE_PAIR, 63, 63, GROUP_A_RESET, 2, 2, 2, 2);
        send_candidate(STYLE_RANGE);
        load_config(MODE_PAIR_SQ, 0, 0, GROUP_A_RESET, 2, 2, 2, 2);
        send_candidate(STYLE_RANGE);
        load_config(MODE_PAIR_SQ, 5, 0, GROUP_A_RESET, 2, 2, 2, 2);
        send_candidate(STYLE_RANGE);
        load_config(MODE_PAIR_SQ, 63, 63, GROUP_A_RESET, 2, 2, 2, 2);
        send_candidate(STYLE_RANGE);
        // size zero groups hold a single coordinate
        load_config(MODE_GROUP, 4, 20, 0, 0, 0, 0, 0);
        send_candidate(STYLE_RANGE);
        // first group never completes, its terms are dropped
        load_config(MODE_GROUP, 4, 20, 63, 63, 63, 63, 63);
        send_candidate(STYLE_RANGE);
        load_config(MODE_GROUP, 4, 20, 7, 7, 7, 7, 7);
        send_candidate(STYLE_RANGE);
        load_config(MODE_GROUP, 4, 20, 7, 7, 7, 7, 9);
        send_candidate(STYLE_RANGE);
        load_config(MODE_GROUP, 4, 20, 36, 1, 1, 1, 1);
        send_candidate(STYLE_RANGE);
    endtask

    // Coordinate extremes, in range and across the full 15-bit field
    task automatic test_coord_extremes();
        load_config(MODE_STAR, 36, 0, GROUP_A_RESET, 2, 2, 2, 2);
        send_candidate(STYLE_CORNER);
        load_config(MODE_PAIR, 18, 0, GROUP_A_RESET, 2, 2, 2, 2);
        send_candidate(STYLE_WIDE);
        load_config(MODE_PAIR_SQ, 9, 0, GROUP_A_RESET, 2, 2, 2, 2);
        send_candidate(STYLE_CORNER);
        send_candidate(STYLE_WIDE);
        load_config(MODE_GROUP, 4, 20, 8, 2, 2, 2, 2);
        send_candidate(STYLE_WIDE);
        send_candidate(STYLE_CORNER);
    endtask

    // near_optimum window edges, also in pass-through mode
    task automatic test_near_flag();
        load_config(MODE_THROUGH, 4, 20, 8, 2, 2, 2, 2);
        send_candidate(STYLE_NEAR);
        send_candidate(STYLE_NEAR_MISS);
        load_config(MODE_PAIR, 9, 18, 8, 2, 2, 2, 2);
        send_candidate(STYLE_NEAR);
        send_candidate(STYLE_NEAR_MISS);
        send_candidate(STYLE_NEAR_MISS);
    endtask

    function automatic int rand_count(input int hi_common);
        return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, hi_common);
    endfunction

    // Random configurations, each followed by a few random candidates
    task automatic test_random_candidates();
        int                first_item;
        int                runs;
        int                pick;
        logic [MODE_W-1:0] all_modes [8];
        logic [MODE_W-1:0] main_modes [4];
        logic [MODE_W-1:0] m;
        coord_style_t      style;
        all_modes  = '{MODE_THROUGH, MODE_STAR, MODE_PAIR, MODE_PAIR_SQ, MODE_GROUP,
                       MODE_SPARE_5, MODE_SPARE_6, MODE_SPARE_7};
        main_modes = '{MODE_STAR, MODE_PAIR, MODE_PAIR_SQ, MODE_GROUP};
        first_item = items_sent;
        while (items_sent - first_item < RANDOM_ITEMS)
        begin
            idle_off = 1'b0;
            m = ($urandom_range(0, 9) == 0) ? all_modes[$urandom_range(0, 7)]
                                            : main_modes[$urandom_range(0, 3)];
            load_config(m, rand_count(36), rand_count(36), rand_count(10),
                        rand_count(10), rand_count(10), rand_count(10), rand_count(10));
            runs = $urandom_range(1, 3);
            repeat (runs)
            begin
                idle_off = ($urandom_range(0, 4) == 0);
                pick     = $urandom_range(0, 19);
                if (pick < 14)
                    style = STYLE_RANGE;
                else if (pick < 16)
                    style = STYLE_NEAR;
                else if (pick < 18)
                    style = STYLE_NEAR_MISS;
                else if (pick == 18)
                    style = STYLE_WIDE;
                else
                    style = STYLE_CORNER;
                send_candidate(style);
            end
        end
        idle_off = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        in_valid    <= 1'b0;
        coord_value <= '0;
        cfg_mode     = MODE_RESET;
        cfg_rosen    = ROSEN_RESET;
        cfg_sphere   = SPHERE_RESET;
        cfg_group[0] = GROUP_A_RESET;
        for (int g = 1; g < NUM_GROUPS; g++)
            cfg_group[g] = GROUP_X_RESET;
        clear_candidate();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_config();
        test_every_mode();
        test_count_extremes();
        test_coord_extremes();
        test_near_flag();
        test_random_candidates();

        wait_idle();
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/bfe_pkg.sv
hdl/bfe_regs.sv
hdl/bfe_ctrl.sv
hdl/bfe_dp.sv
hdl/benchmark_fitness_evaluator.sv
test/tb_top.sv
